[sv/safo_pkg.sv]
// shared types and constants for the sprite animation frame offset pipeline
`timescale 1ns / 1ps

package safo_pkg;

    // field widths
    localparam int FRAME_W = 6;
    localparam int MODE_W  = 2;
    localparam int SHIFT_W = 4;
    localparam int CLOCK_W = 31;
    localparam int OFFS_W  = 7;

    // remainder datapath: divisor is 2n or n+1, at most 126
    localparam int DIV_W        = FRAME_W + 1;
    localparam int DIGITS       = 8;
    localparam int REM_STAGES   = 4;
    localparam int DIVIDEND_W   = DIGITS * REM_STAGES;

    // animation modes
    localparam logic [MODE_W-1:0] MODE_NONE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OSCILLATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORWARD   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BACKWARD  = 2'd3;

    // item carried down the pipeline
    typedef struct packed {
        logic [FRAME_W-1:0]    frame_count;
        logic [MODE_W-1:0]     anim_mode;
        logic [DIV_W-1:0]      divisor;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIV_W-1:0]      rem;
    } t_safo_item;

endpackage

[sv/safo_prep.sv]
// first stage: clock shift and divisor selection
`timescale 1ns / 1ps

module safo_prep (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [safo_pkg::FRAME_W-1:0]  i_frame_count,
    input  logic [safo_pkg::MODE_W-1:0]   i_anim_mode,
    input  logic [safo_pkg::SHIFT_W-1:0]  i_speed_shift,
    input  logic [safo_pkg::CLOCK_W-1:0]  i_clock_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output safo_pkg::t_safo_item          o_data
);

    logic                 r_valid;
    safo_pkg::t_safo_item r_data;
    safo_pkg::t_safo_item n_data;
    logic [safo_pkg::CLOCK_W-1:0] shifted;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // shifted clock and modulus; zero frame count gets a harmless divisor of one
    always_comb begin
        shifted            = i_clock_req >> i_speed_shift;
        n_data.frame_count = i_frame_count;
        n_data.anim_mode   = i_anim_mode;
        n_data.dividend    = {{(safo_pkg::DIVIDEND_W - safo_pkg::CLOCK_W){1'b0}}, shifted};
        n_data.rem         = '0;
        if (i_frame_count == '0) begin
            n_data.divisor = safo_pkg::DIV_W'(1);
        end else if (i_anim_mode == safo_pkg::MODE_OSCILLATE) begin
            n_data.divisor = {i_frame_count, 1'b0};
        end else begin
            n_data.divisor = {1'b0, i_frame_count} + safo_pkg::DIV_W'(1);
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

[sv/safo_rem_stage.sv]
// one remainder stage: folds eight dividend bits into the running remainder
`timescale 1ns / 1ps

module safo_rem_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  safo_pkg::t_safo_item i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output safo_pkg::t_safo_item o_data
);

    logic                 r_valid;
    safo_pkg::t_safo_item r_data;
    safo_pkg::t_safo_item n_data;
    logic [safo_pkg::DIV_W:0] part;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // restoring remainder, one dividend bit per step, top bits first
    always_comb begin
        n_data = i_data;
        part   = '0;
        for (int b = 0; b < safo_pkg::DIGITS; b++) begin
            part = {n_data.rem, n_data.dividend[safo_pkg::DIVIDEND_W-1]};
            if (part >= {1'b0, n_data.divisor}) begin
                part = part - {1'b0, n_data.divisor};
            end
            n_data.rem      = part[safo_pkg::DIV_W-1:0];
            n_data.dividend = {n_data.dividend[safo_pkg::DIVIDEND_W-2:0], 1'b0};
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    // partial remainder always stays below the modulus
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.rem < r_data.divisor))
        else $error("remainder not below divisor");

    // a nonzero divisor reaches every stage
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.divisor != '0))
        else $error("zero divisor in remainder stage");

endmodule

[sv/safo_fold.sv]
// last stage: mode mapping, fold and negate, output register
`timescale 1ns / 1ps

module safo_fold (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  safo_pkg::t_safo_item         i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [safo_pkg::OFFS_W-1:0]  o_frame_offset
);

    logic                         r_valid;
    logic [safo_pkg::OFFS_W-1:0]  r_frame_offset;
    logic [safo_pkg::OFFS_W-1:0]  n_frame_offset;
    logic [safo_pkg::DIV_W-1:0]   n_ext;

    assign o_ready        = !r_valid || i_ready;
    assign o_valid        = r_valid;
    assign o_frame_offset = r_frame_offset;

    // map remainder to offset by mode
    always_comb begin
        n_ext = {1'b0, i_data.frame_count};
        if (i_data.frame_count == '0) begin
            n_frame_offset = '0;
        end else begin
            case (i_data.anim_mode)
                safo_pkg::MODE_OSCILLATE: begin
                    if (i_data.rem < n_ext) begin
                        n_frame_offset = i_data.rem;
                    end else begin
                        n_frame_offset = i_data.divisor - i_data.rem;
                    end
                end
                safo_pkg::MODE_FORWARD:  n_frame_offset = i_data.rem;
                safo_pkg::MODE_BACKWARD: n_frame_offset = '0 - i_data.rem;
                default:                 n_frame_offset = '0;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_frame_offset <= n_frame_offset;
        end
    end

    // offset never reaches the most negative code
    a_offs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_frame_offset != {1'b1, {(safo_pkg::OFFS_W-1){1'b0}}}))
        else $error("frame offset out of range");

    // zero frame count always gives a zero offset
    a_zero_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_data.frame_count == '0)) |=> (r_frame_offset == '0))
        else $error("nonzero offset for zero frame count");

endmodule

[sv/sprite_animation_frame_offset.sv]
// top level of the sprite animation frame offset pipeline
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------
//   input    | i_valid / o_ready  | i_frame_count, i_anim_mode, i_speed_shift,
//            |                    | i_clock_req
//   output   | o_valid / i_ready  | o_frame_offset
//
// one transaction per cycle sustained while the output is not stalled; six
// register stages: the shift stage, four remainder stages of eight dividend
// bits each, and the fold stage.
// synchronous active-low reset clears all stage valid bits; no other state.
// each stage holds its transaction while the next stage is full and stalled,
// and empty stages fill in behind a stalled output.
`timescale 1ns / 1ps

module sprite_animation_frame_offset (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [safo_pkg::FRAME_W-1:0]  i_frame_count,
    input  logic [safo_pkg::MODE_W-1:0]   i_anim_mode,
    input  logic [safo_pkg::SHIFT_W-1:0]  i_speed_shift,
    input  logic [safo_pkg::CLOCK_W-1:0]  i_clock_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [safo_pkg::OFFS_W-1:0]   o_frame_offset
);

    logic                 stg_valid [safo_pkg::REM_STAGES+1];
    logic                 stg_ready [safo_pkg::REM_STAGES+1];
    safo_pkg::t_safo_item stg_data  [safo_pkg::REM_STAGES+1];

    // shift and divisor stage
    safo_prep u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_frame_count (i_frame_count),
        .i_anim_mode   (i_anim_mode),
        .i_speed_shift (i_speed_shift),
        .i_clock_req   (i_clock_req),
        .o_valid       (stg_valid[0]),
        .i_ready       (stg_ready[0]),
        .o_data        (stg_data[0])
    );

    // remainder stages
    for (genvar s = 0; s < safo_pkg::REM_STAGES; s++) begin : g_rem
        safo_rem_stage u_rem (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[s]),
            .o_ready (stg_ready[s]),
            .i_data  (stg_data[s]),
            .o_valid (stg_valid[s+1]),
            .i_ready (stg_ready[s+1]),
            .o_data  (stg_data[s+1])
        );
    end

    // fold and output stage
    safo_fold u_fold (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (stg_valid[safo_pkg::REM_STAGES]),
        .o_ready        (stg_ready[safo_pkg::REM_STAGES]),
        .i_data         (stg_data[safo_pkg::REM_STAGES]),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_offset (o_frame_offset)
    );

    // an empty output slot means the whole pipe can take a transaction
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output stage");

endmodule
